// ----- design/alht_pkg.sv -----
package alht_pkg;

  // Field widths
  localparam int KNOB_W     = 11;
  localparam int THR_W      = 11;
  localparam int ALT_W      = 18;
  localparam int CLIMB_W    = 15;
  localparam int GAIN_W     = 10;
  localparam int ERR_W      = 34;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 27;
  localparam int MUL_P_W = 63;

  // Knob mapping
  localparam logic [KNOB_W-1:0] KNOB_ZERO = 11'd1000;
  localparam logic [KNOB_W-1:0] KNOB_FULL = 11'd2000;
  localparam logic [GAIN_W-1:0] GAIN_MAX  = 10'd1000;

  // Error filter saturation, signed 34-bit range
  localparam logic signed [ERR_W:0] ERR_MAX = 35'sd8589934591;
  localparam logic signed [ERR_W:0] ERR_MIN = -35'sd8589934592;

  // Target scaling: y = floor(prod / 2^24), clipped to 22 bits, then
  // floor(y / 1000) through an offset that keeps the dividend positive.
  localparam logic signed [21:0] Y_MAX       = 22'sd2097151;
  localparam logic signed [21:0] Y_MIN       = -22'sd2097152;
  localparam logic signed [24:0] DIV_OFFSET  = 25'sd2098000;
  localparam logic [22:0]        RECIP_K     = 23'd4294967;
  localparam logic [22:0]        DIV_BASE    = 23'd1000;
  // 1500 us center minus the quotient offset of 2098
  localparam logic signed [13:0] TARGET_BIAS = -14'sd598;

  localparam logic [6:0] RATE_CORRECTION = 7'd1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HOLD_THRESHOLD = 3'd0,
    REG_ERROR_SMOOTHING = 3'd1,
    REG_BASE_GAIN      = 3'd2,
    REG_THROTTLE_MIN   = 3'd3,
    REG_THROTTLE_MAX   = 3'd4,
    REG_SLEW_STEP      = 3'd5,
    REG_CLIMB_LIMIT    = 3'd6,
    REG_DESCENT_LIMIT  = 3'd7
  } alht_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0]         hold_threshold;
    logic [15:0]               error_smoothing;
    logic [15:0]               base_gain;
    logic [THR_W-1:0]          throttle_min;
    logic [THR_W-1:0]          throttle_max;
    logic [7:0]                slew_step;
    logic signed [CLIMB_W-1:0] climb_limit;
    logic signed [CLIMB_W-1:0] descent_limit;
  } alht_cfg_t;

  typedef struct packed {
    logic [KNOB_W-1:0]         hold_knob;
    logic [THR_W-1:0]          throttle_stick;
    logic signed [ALT_W-1:0]   altitude_cm;
    logic signed [CLIMB_W-1:0] climb_rate_cms;
    logic                      sensor_ok;
  } alht_tick_t;

  typedef struct packed {
    logic [THR_W-1:0]  throttle_out;
    logic              hold_engaged;
    logic [GAIN_W-1:0] knob_gain;
  } alht_result_t;

  typedef struct packed {
    logic engage;
  } alht_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_GAIN,
    ST_MUL_SMOOTH,
    ST_FILTER,
    ST_MUL_TARGET,
    ST_SCALE,
    ST_MUL_RECIP,
    ST_CORRECT,
    ST_TARGET,
    ST_SLEW,
    ST_COMMIT
  } alht_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PREP,
    OP_MUL_GAIN,
    OP_MUL_SMOOTH,
    OP_FILTER,
    OP_MUL_TARGET,
    OP_SCALE,
    OP_MUL_RECIP,
    OP_CORRECT,
    OP_TARGET,
    OP_SLEW,
    OP_COMMIT
  } alht_op_t;

  // Clamp to [lo, hi]; below lo wins over above hi.
  function automatic logic [THR_W-1:0] sat_throttle(
    input logic signed [13:0] x,
    input logic [THR_W-1:0]   lo,
    input logic [THR_W-1:0]   hi
  );
    logic [THR_W-1:0] res;
    if (x < $signed({3'b000, lo})) begin
      res = lo;
    end else if (x > $signed({3'b000, hi})) begin
      res = hi;
    end else begin
      res = x[THR_W-1:0];
    end
    return res;
  endfunction

endpackage

// ----- design/alht_if.sv -----
interface alht_tick_if;
  import alht_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [KNOB_W-1:0]         hold_knob;
  logic [THR_W-1:0]          throttle_stick;
  logic signed [ALT_W-1:0]   altitude_cm;
  logic signed [CLIMB_W-1:0] climb_rate_cms;
  logic                      sensor_ok;

  modport source (
    output valid, hold_knob, throttle_stick, altitude_cm, climb_rate_cms, sensor_ok,
    input  ready
  );
  modport sink (
    input  valid, hold_knob, throttle_stick, altitude_cm, climb_rate_cms, sensor_ok,
    output ready
  );
endinterface

interface alht_result_if;
  import alht_pkg::*;

  logic              valid;
  logic              ready;
  logic [THR_W-1:0]  throttle_out;
  logic              hold_engaged;
  logic [GAIN_W-1:0] knob_gain;

  modport source (
    output valid, throttle_out, hold_engaged, knob_gain,
    input  ready
  );
  modport sink (
    input  valid, throttle_out, hold_engaged, knob_gain,
    output ready
  );
endinterface

interface alht_cfg_if;
  import alht_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ----- design/alht_cfg_regs.sv -----
module alht_cfg_regs (
  input  logic                 clk,
  input  logic                 rst,
  alht_cfg_if.sink             cfg,
  output alht_pkg::alht_cfg_t  regs
);
  import alht_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.hold_threshold  <= 10'd500;
      regs.error_smoothing <= 16'd6554;
      regs.base_gain       <= 16'd256;
      regs.throttle_min    <= 11'd1100;
      regs.throttle_max    <= 11'd1900;
      regs.slew_step       <= 8'd2;
      regs.climb_limit     <= 15'sd200;
      regs.descent_limit   <= -15'sd200;
    end else if (cfg.valid) begin
      unique case (alht_reg_t'(cfg.index))
        REG_HOLD_THRESHOLD:  regs.hold_threshold  <= cfg.data[GAIN_W-1:0];
        REG_ERROR_SMOOTHING: regs.error_smoothing <= cfg.data[15:0];
        REG_BASE_GAIN:       regs.base_gain       <= cfg.data[15:0];
        REG_THROTTLE_MIN:    regs.throttle_min    <= cfg.data[THR_W-1:0];
        REG_THROTTLE_MAX:    regs.throttle_max    <= cfg.data[THR_W-1:0];
        REG_SLEW_STEP:       regs.slew_step       <= cfg.data[7:0];
        REG_CLIMB_LIMIT:     regs.climb_limit     <= $signed(cfg.data[CLIMB_W-1:0]);
        REG_DESCENT_LIMIT:   regs.descent_limit   <= $signed(cfg.data[CLIMB_W-1:0]);
      endcase
    end
  end

endmodule

// ----- design/alht_ctrl.sv -----
module alht_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tick_valid,
  output logic                   tick_ready,
  output logic                   result_valid,
  input  logic                   result_ready,
  input  alht_pkg::alht_status_t status,
  output alht_pkg::alht_op_t     op
);
  import alht_pkg::*;

  alht_state_t state, state_next;
  logic        result_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    state_next        = state;
    op                = OP_NONE;
    tick_ready        = (state == ST_IDLE);
    result_valid_next = result_valid && !result_ready;
    unique case (state)
      ST_IDLE: begin
        if (tick_valid) begin
          op         = OP_LOAD;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        op         = OP_PREP;
        state_next = status.engage ? ST_MUL_GAIN : ST_COMMIT;
      end
      ST_MUL_GAIN: begin
        op         = OP_MUL_GAIN;
        state_next = ST_MUL_SMOOTH;
      end
      ST_MUL_SMOOTH: begin
        op         = OP_MUL_SMOOTH;
        state_next = ST_FILTER;
      end
      ST_FILTER: begin
        op         = OP_FILTER;
        state_next = ST_MUL_TARGET;
      end
      ST_MUL_TARGET: begin
        op         = OP_MUL_TARGET;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        op         = OP_SCALE;
        state_next = ST_MUL_RECIP;
      end
      ST_MUL_RECIP: begin
        op         = OP_MUL_RECIP;
        state_next = ST_CORRECT;
      end
      ST_CORRECT: begin
        op         = OP_CORRECT;
        state_next = ST_TARGET;
      end
      ST_TARGET: begin
        op         = OP_TARGET;
        state_next = ST_SLEW;
      end
      ST_SLEW: begin
        op         = OP_SLEW;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the output register is free or being drained
        if (!result_valid || result_ready) begin
          op                = OP_COMMIT;
          state_next        = ST_IDLE;
          result_valid_next = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/alht_datapath.sv -----
module alht_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  alht_pkg::alht_op_t     op,
  input  alht_pkg::alht_cfg_t    regs,
  input  alht_pkg::alht_tick_t   tick,
  output alht_pkg::alht_status_t status,
  output alht_pkg::alht_result_t result
);
  import alht_pkg::*;

  // Persistent controller state
  logic                    hold_active;
  logic signed [ALT_W-1:0] target_altitude;
  logic signed [ERR_W-1:0] filtered_error;
  logic [THR_W-1:0]        held_throttle;

  // Per-item working registers
  logic [THR_W-1:0]          stick;
  logic signed [ALT_W-1:0]   alt;
  logic signed [CLIMB_W-1:0] climb;
  logic [GAIN_W-1:0]         gain;
  logic                      engage;
  logic signed [ALT_W-1:0]   tgt_alt_w;
  logic signed [ERR_W-1:0]   f_w;
  logic [THR_W-1:0]          held_w;
  logic signed [35:0]        diff;
  logic [25:0]               bgg;
  logic signed [MUL_P_W-1:0] prod;
  logic signed [ERR_W-1:0]   f_new;
  logic [22:0]               u;
  logic [12:0]               q;
  logic [THR_W-1:0]          tgt_cl;
  logic signed [12:0]        held_s;

  // Combinational terms
  logic [GAIN_W-1:0]         gain_c;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [18:0]        alt_diff;
  logic signed [35:0]        diff_c;
  logic signed [35:0]        filt_inc;
  logic signed [ERR_W:0]     filt_sum;
  logic signed [ERR_W-1:0]   f_sat;
  logic signed [38:0]        y;
  logic signed [21:0]        y_cl;
  logic signed [24:0]        u_sum;
  logic [12:0]               q0;
  logic [22:0]               q0k;
  logic [23:0]               rem;
  logic signed [13:0]        tgt_raw;
  logic signed [11:0]        delta;
  logic signed [11:0]        step_s;
  logic signed [12:0]        slewed;
  logic signed [12:0]        nudged;
  logic [THR_W-1:0]          held_cl;

  assign status.engage = engage;

  // Knob to gain, 0..1000 thousandths
  always_comb begin
    if (tick.hold_knob <= KNOB_ZERO) begin
      gain_c = '0;
    end else if (tick.hold_knob >= KNOB_FULL) begin
      gain_c = GAIN_MAX;
    end else begin
      gain_c = GAIN_W'(tick.hold_knob - KNOB_ZERO);
    end
  end

  // Shared multiplier operands
  always_comb begin
    unique case (op)
      OP_MUL_GAIN: begin
        mul_a = $signed(MUL_A_W'(regs.base_gain));
        mul_b = $signed(MUL_B_W'(gain));
      end
      OP_MUL_SMOOTH: begin
        mul_a = diff;
        mul_b = $signed(MUL_B_W'(regs.error_smoothing));
      end
      OP_MUL_TARGET: begin
        mul_a = MUL_A_W'(f_new);
        mul_b = $signed(MUL_B_W'(bgg));
      end
      OP_MUL_RECIP: begin
        mul_a = $signed(MUL_A_W'(u));
        mul_b = $signed(MUL_B_W'(RECIP_K));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Error in Q.16 minus the filter state
  assign alt_diff = 19'(tgt_alt_w) - 19'(alt);
  assign diff_c   = 36'($signed({alt_diff, 16'h0000})) - 36'(f_w);

  // Filter update with saturation to 34 bits
  assign filt_inc = $signed(prod[51:16]);
  assign filt_sum = (ERR_W+1)'(f_w) + (ERR_W+1)'(filt_inc);
  always_comb begin
    if (filt_sum > ERR_MAX) begin
      f_sat = ERR_MAX[ERR_W-1:0];
    end else if (filt_sum < ERR_MIN) begin
      f_sat = ERR_MIN[ERR_W-1:0];
    end else begin
      f_sat = filt_sum[ERR_W-1:0];
    end
  end

  // Scale by 2^-24 and clip to what can still move the clamped target
  assign y = $signed(prod[MUL_P_W-1:24]);
  always_comb begin
    if (y > 39'(Y_MAX)) begin
      y_cl = Y_MAX;
    end else if (y < 39'(Y_MIN)) begin
      y_cl = Y_MIN;
    end else begin
      y_cl = y[21:0];
    end
  end
  assign u_sum = 25'(y_cl) + DIV_OFFSET;

  // Reciprocal quotient is exact or one short; fix with one compare
  assign q0  = prod[44:32];
  assign q0k = 23'(q0) * DIV_BASE;
  assign rem = {1'b0, u} - {1'b0, q0k};

  assign tgt_raw = $signed({1'b0, q}) + TARGET_BIAS;

  // Slew toward the target, then apply the climb-rate nudge
  assign delta  = $signed({1'b0, tgt_cl}) - $signed({1'b0, held_w});
  assign step_s = $signed({4'b0000, regs.slew_step});
  always_comb begin
    if (delta > step_s) begin
      slewed = $signed({2'b00, held_w}) + $signed({5'b00000, regs.slew_step});
    end else if (delta < -step_s) begin
      slewed = $signed({2'b00, held_w}) - $signed({5'b00000, regs.slew_step});
    end else begin
      slewed = $signed({2'b00, tgt_cl});
    end
    if (climb > regs.climb_limit) begin
      nudged = slewed - $signed(13'(RATE_CORRECTION));
    end else if (climb < regs.descent_limit) begin
      nudged = slewed + $signed(13'(RATE_CORRECTION));
    end else begin
      nudged = slewed;
    end
  end

  assign held_cl = sat_throttle(14'(held_s), regs.throttle_min, regs.throttle_max);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_active     <= 1'b0;
      target_altitude <= '0;
      filtered_error  <= '0;
      held_throttle   <= '0;
    end else if (op == OP_COMMIT) begin
      if (engage) begin
        hold_active     <= 1'b1;
        target_altitude <= tgt_alt_w;
        filtered_error  <= f_new;
        held_throttle   <= held_cl;
      end else begin
        hold_active   <= 1'b0;
        held_throttle <= stick;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        stick  <= tick.throttle_stick;
        alt    <= tick.altitude_cm;
        climb  <= tick.climb_rate_cms;
        gain   <= gain_c;
        engage <= tick.sensor_ok && (gain_c > regs.hold_threshold);
      end
      OP_PREP: begin
        // on engaging, seed from this tick
        tgt_alt_w <= hold_active ? target_altitude : alt;
        f_w       <= hold_active ? filtered_error : '0;
        held_w    <= hold_active ? held_throttle : stick;
      end
      OP_MUL_GAIN: begin
        prod <= mul_p;
        diff <= diff_c;
      end
      OP_MUL_SMOOTH: begin
        bgg  <= prod[25:0];
        prod <= mul_p;
      end
      OP_FILTER: begin
        f_new <= f_sat;
      end
      OP_MUL_TARGET: begin
        prod <= mul_p;
      end
      OP_SCALE: begin
        u <= u_sum[22:0];
      end
      OP_MUL_RECIP: begin
        prod <= mul_p;
      end
      OP_CORRECT: begin
        q <= (rem >= 24'(DIV_BASE)) ? q0 + 13'd1 : q0;
      end
      OP_TARGET: begin
        tgt_cl <= sat_throttle(tgt_raw, regs.throttle_min, regs.throttle_max);
      end
      OP_SLEW: begin
        held_s <= nudged;
      end
      OP_COMMIT: begin
        result.throttle_out <= engage ? held_cl : stick;
        result.hold_engaged <= engage;
        result.knob_gain    <= gain;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- design/altitude_hold_throttle_core.sv -----
// Altitude hold throttle controller, one update per control tick.
// Channels: tick (sink) carries knob, stick, altitude, climb rate and the
// sensor-ok flag; result (source) returns throttle_out, hold_engaged and
// knob_gain, one result beat per tick beat; cfg (sink) writes one of eight
// registers by index and is always ready. Write cfg only while idle.
// Update: a tick that engages or keeps hold runs a sequence of three
// products and a reciprocal division step on one shared 36x27 multiplier;
// a tick with hold off goes from prep straight to commit. The next tick
// is taken only once the current one has committed.
// Reset (synchronous, active high) drops hold, clears the saved altitude,
// error filter and held throttle, and loads the register defaults.
// A stalled receiver: the result register holds its beat; the next tick
// is still accepted and computed, then waits at commit until the output
// register drains, so no beat is lost or overwritten.
module altitude_hold_throttle_core (
  input  logic       clk,
  input  logic       rst,
  alht_tick_if.sink   tick,
  alht_result_if.source result,
  alht_cfg_if.sink    cfg
);
  import alht_pkg::*;

  alht_cfg_t    regs;
  alht_status_t status;
  alht_op_t     op;
  alht_tick_t   tick_data;
  alht_result_t result_data;
  logic         tick_ready;
  logic         result_valid;

  // Register file: always ready, takes the write on each cfg beat
  alht_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Sequencer: one tick at a time, steps the datapath through the update
  alht_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick.valid),
    .tick_ready   (tick_ready),
    .result_valid (result_valid),
    .result_ready (result.ready),
    .status       (status),
    .op           (op)
  );

  assign tick_data.hold_knob      = tick.hold_knob;
  assign tick_data.throttle_stick = tick.throttle_stick;
  assign tick_data.altitude_cm    = tick.altitude_cm;
  assign tick_data.climb_rate_cms = tick.climb_rate_cms;
  assign tick_data.sensor_ok      = tick.sensor_ok;

  // Arithmetic, hold state and the result register
  alht_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .op     (op),
    .regs   (regs),
    .tick   (tick_data),
    .status (status),
    .result (result_data)
  );

  assign tick.ready          = tick_ready;
  assign result.valid        = result_valid;
  assign result.throttle_out = result_data.throttle_out;
  assign result.hold_engaged = result_data.hold_engaged;
  assign result.knob_gain    = result_data.knob_gain;

endmodule
